// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the meteor trail frame engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define MTFE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define MTFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mtfe_pkg.sv -----
// Shared types, constants and register codes of the meteor trail frame engine.
package mtfe_pkg;

  localparam int MAX_PIXELS = 64;
  localparam int IDX_W      = $clog2(MAX_PIXELS);
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
  localparam int PIX_IDX_W  = 6;
  localparam int POS_W      = 10;
  localparam int MASK_W     = 64;

  localparam logic [7:0] FADE_FLOOR = 8'd10;

  localparam logic [23:0] COLOR_RST  = 24'hFFFFFF;
  localparam logic [7:0]  LENGTH_RST = 8'd5;
  localparam logic [7:0]  DECAY_RST  = 8'd64;
  localparam logic        RND_RST    = 1'b1;
  localparam logic [6:0]  ACTIVE_RST = 7'd64;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic fade;
    logic paint;
  } px_ctrl_t;

  typedef enum logic [2:0] {
    REG_COLOR  = 3'd0,
    REG_LENGTH = 3'd1,
    REG_DECAY  = 3'd2,
    REG_RANDOM = 3'd3,
    REG_ACTIVE = 3'd4
  } reg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

endpackage

// ----- hdl/mtfe_cell.sv -----
// One pixel cell of the rotating pixel row.
module mtfe_cell
  import mtfe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic clear_i,
  input  logic shift_i,
  input  rgb_t pix_i,
  output rgb_t pix_o
);

  rgb_t pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else if (clear_i) begin
      pix_q <= '0;
    end else if (shift_i) begin
      pix_q <= pix_i;
    end
  end

  assign pix_o = pix_q;

endmodule

// ----- hdl/mtfe_fade.sv -----
// Fade and paint unit applied to the pixel leaving the head of the row.
module mtfe_fade
  import mtfe_pkg::*;
(
  input  rgb_t       pix_i,
  input  logic [7:0] decay_i,
  input  rgb_t       color_i,
  input  px_ctrl_t   ctrl_i,
  output rgb_t       pix_o
);

  function automatic logic [7:0] fade_ch(input logic [7:0] c, input logic [7:0] d);
    logic [15:0] prod;
    prod = 16'(c) * 16'(d);
    if (c <= FADE_FLOOR) begin
      return 8'd0;
    end
    return c - prod[15:8];
  endfunction

  rgb_t faded;

  always_comb begin
    faded.red   = fade_ch(pix_i.red, decay_i);
    faded.green = fade_ch(pix_i.green, decay_i);
    faded.blue  = fade_ch(pix_i.blue, decay_i);
  end

  // Paint wins over fade: the meteor is drawn after the whole strip fades.
  always_comb begin
    priority if (ctrl_i.paint) begin
      pix_o = color_i;
    end else if (ctrl_i.fade) begin
      pix_o = faded;
    end else begin
      pix_o = pix_i;
    end
  end

endmodule

// ----- hdl/meteor_trail_frame_engine.sv -----
// Top level of the meteor trail frame engine: register file, frame sequencer, pixel row.
//
// Usage: each slave-side transfer is one animation frame carrying the meteor head position,
// the per-pixel fade mask and a restart flag. The block keeps MAX_PIXELS RGB pixels in a
// row of cells that rotates by one place per step; the pixel leaving cell 0 is faded and,
// if it lies under the meteor, painted, then written back at the far end of the row.
// A frame always takes MAX_PIXELS steps (one full turn of the row), and a step
// of an active pixel also sends one master-side transfer with that pixel; tlast marks the
// last active pixel. Inactive pixels pass through the turn unchanged and send nothing.
// The first pixel goes out through the sequencer state and then the output register.
// When the receiver never stalls the row turns one pixel step per cycle; a new frame is
// taken only when the block is idle again after the turn.
// A restart clears every cell in the cycle the frame is taken.
// When the receiver stalls, the output register holds its pixel and the row stops turning
// until the pixel is taken; steps of inactive pixels also wait for a free output register.
// Reset: every pixel goes black, the registers take their reset values, the block is idle.
// Configuration writes (cfg_we_i) take effect at once and belong between frames only.
`include "assert_macros.svh"

module meteor_trail_frame_engine
  import mtfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_wdata_i,
  // frame input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // head_position [7:0], fade_mask [71:8]
  input  logic        s_axis_tuser,   // restart [0]
  // pixel output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // pixel_index [5:0], red [13:6], green [21:14],
                                      // blue [29:22], zero [31:30]
  output logic        m_axis_tlast    // frame_last
);

  // Configuration registers.
  rgb_t       color_q;
  logic [7:0] length_q;
  logic [7:0] decay_q;
  logic       rnd_q;
  logic [6:0] active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q  <= COLOR_RST;
      length_q <= LENGTH_RST;
      decay_q  <= DECAY_RST;
      rnd_q    <= RND_RST;
      active_q <= ACTIVE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_COLOR:  color_q  <= cfg_wdata_i;
        REG_LENGTH: length_q <= cfg_wdata_i[7:0];
        REG_DECAY:  decay_q  <= cfg_wdata_i[7:0];
        REG_RANDOM: rnd_q    <= cfg_wdata_i[0];
        REG_ACTIVE: active_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // Clamp the active count to the row length.
  logic [CNT_W-1:0] n_act;
  assign n_act = (active_q > 7'(MAX_PIXELS)) ? CNT_W'(MAX_PIXELS) : CNT_W'(active_q);

  // Frame sequencer.
  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q;
  logic             accept;
  logic             advance;
  logic             emit;
  logic             out_free;
  logic             last_step;

  logic                    out_valid_q;
  logic [PIX_IDX_W-1:0]    out_idx_q;
  rgb_t                    out_pix_q;
  logic                    out_last_q;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign emit      = CNT_W'(idx_q) < n_act;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign last_step = idx_q == IDX_W'(MAX_PIXELS - 1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_RUN;
      ST_RUN:  if (advance && last_step) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    advance       = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_RUN:  advance = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (advance) begin
        idx_q <= last_step ? '0 : idx_q + 1'b1;
      end
    end
  end

  // Frame operands: head, first painted position and the fade mask, shifted one per step.
  logic signed [POS_W-1:0] head_q;
  logic signed [POS_W-1:0] lo_q;
  logic [MAX_PIXELS-1:0]   mask_q;
  logic signed [POS_W-1:0] head_ext;

  assign head_ext = POS_W'($signed(s_axis_tdata[7:0]));

  always_ff @(posedge clk_i) begin
    if (accept) begin
      head_q <= head_ext;
      lo_q   <= head_ext - $signed(POS_W'(length_q)) + POS_W'(1);
      mask_q <= s_axis_tdata[8 +: MAX_PIXELS];
    end else if (advance) begin
      mask_q <= mask_q >> 1;
    end
  end

  // Per-step control for the pixel at the head of the row.
  px_ctrl_t                ctrl;
  logic signed [POS_W-1:0] pos;

  assign pos        = $signed(POS_W'(idx_q));
  assign ctrl.fade  = emit && (!rnd_q || mask_q[0]);
  assign ctrl.paint = emit && (pos >= lo_q) && (pos <= head_q);

  // Pixel row.
  rgb_t cell_pix [MAX_PIXELS];
  rgb_t new_pix;
  logic clear;

  assign clear = accept && s_axis_tuser;

  mtfe_fade u_fade (
    .pix_i   (cell_pix[0]),
    .decay_i (decay_q),
    .color_i (color_q),
    .ctrl_i  (ctrl),
    .pix_o   (new_pix)
  );

  for (genvar k = 0; k < MAX_PIXELS; k++) begin : g_cell
    rgb_t feed;
    if (k == MAX_PIXELS - 1) begin : g_tail
      assign feed = new_pix;
    end else begin : g_mid
      assign feed = cell_pix[k+1];
    end
    mtfe_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (clear),
      .shift_i (advance),
      .pix_i   (feed),
      .pix_o   (cell_pix[k])
    );
  end

  // Output register.
  logic load_out;
  assign load_out = advance && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_idx_q  <= PIX_IDX_W'(idx_q);
      out_pix_q  <= new_pix;
      out_last_q <= CNT_W'(idx_q) == n_act - CNT_W'(1);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_pix_q.blue, out_pix_q.green, out_pix_q.red, out_idx_q};
  assign m_axis_tlast  = out_last_q;

  `MTFE_ASSERT(a_idle_at_start, (state_q == ST_IDLE) |-> (idx_q == '0), "step count not at zero while idle")
  `MTFE_ASSERT_NEXT(a_accept_runs, accept, state_q == ST_RUN, "frame taken but row not turning")
  `MTFE_ASSERT(a_no_overwrite, (out_valid_q && !m_axis_tready) |-> !load_out, "pending pixel overwritten")

endmodule
